// ----- rtl/olist_pkg.sv -----
// olist_pkg: types and codes shared by the ordered list engine
// request and result transaction structs, operation codes, allocator control
// no dependencies
`default_nettype none

package olist_pkg;

    localparam int VALUE_W = 32;
    localparam int FUNC_W  = 2;
    localparam int POS_W   = 6;
    localparam int COUNT_W = 7;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]         func;
        logic signed [VALUE_W-1:0] value;
    } request_t;

    typedef struct packed {
        logic               success;
        logic [POS_W-1:0]   position;
        logic               is_empty;
        logic [COUNT_W-1:0] entry_count;
    } result_t;

    typedef struct packed {
        logic pop;
        logic push;
    } alloc_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/olist_ram.sv -----
// olist_ram: generic single write port, single read port ram, registered read
// no dependencies
`default_nettype none

module olist_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/olist_alloc.sv -----
// olist_alloc: slot allocator, fresh slot counter plus a stack of released slots
// depends on olist_pkg and olist_ram
`default_nettype none

module olist_alloc
    import olist_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire alloc_ctrl_t                 ctrl,
    input  wire logic [$clog2(CAPACITY)-1:0] push_slot,
    output logic      [$clog2(CAPACITY)-1:0] slot
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] sp_reg, sp_next;
    logic [CNT_W-1:0] fresh_reg, fresh_next;
    logic             from_stack_reg, from_stack_next;
    logic [IDX_W-1:0] fresh_slot_reg, fresh_slot_next;
    logic [CNT_W-1:0] sp_dec;
    logic [IDX_W-1:0] stack_rdata;

    assign sp_dec = sp_reg - CNT_W'(1);

    olist_ram #(
        .WIDTH(IDX_W),
        .DEPTH(CAPACITY)
    ) u_stack (
        .clk  (clk),
        .we   (ctrl.push),
        .waddr(sp_reg[IDX_W-1:0]),
        .wdata(push_slot),
        .raddr(sp_dec[IDX_W-1:0]),
        .rdata(stack_rdata)
    );

    always_comb
    begin
        sp_next         = sp_reg;
        fresh_next      = fresh_reg;
        from_stack_next = from_stack_reg;
        fresh_slot_next = fresh_slot_reg;
        if (ctrl.push)
        begin
            sp_next = sp_reg + CNT_W'(1);
        end
        else if (ctrl.pop)
        begin
            if (sp_reg != '0)
            begin
                sp_next         = sp_dec;
                from_stack_next = 1'b1;
            end
            else
            begin
                fresh_slot_next = fresh_reg[IDX_W-1:0];
                fresh_next      = fresh_reg + CNT_W'(1);
                from_stack_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg         <= '0;
            fresh_reg      <= '0;
            from_stack_reg <= 1'b0;
            fresh_slot_reg <= '0;
        end
        else
        begin
            sp_reg         <= sp_next;
            fresh_reg      <= fresh_next;
            from_stack_reg <= from_stack_next;
            fresh_slot_reg <= fresh_slot_next;
        end
    end

    assign slot = from_stack_reg ? stack_rdata : fresh_slot_reg;

    // released slots can never outnumber slots handed out
    assert property (@(posedge clk) disable iff (!rst_n) sp_reg <= fresh_reg)
        else $error("olist_alloc: free stack deeper than slots handed out");

    assert property (@(posedge clk) disable iff (!rst_n)
        fresh_reg <= CNT_W'(CAPACITY))
        else $error("olist_alloc: fresh slot counter past capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.pop && ctrl.push))
        else $error("olist_alloc: pop and push in the same cycle");

endmodule

`default_nettype wire

// ----- rtl/ordered_list_engine.sv -----
// ordered_list_engine: bounded linked list of signed words, newest first
// depends on olist_pkg, olist_ram and olist_alloc
//
// usage:
//   a request transaction (func, value) is taken at a rising edge with start
//   high and busy low. insert puts the value at the head, search finds the
//   first equal entry from the head, remove unlinks the first equal entry.
//   busy stays high while a request is in work.
//   one result transaction per request: done is high for exactly one cycle
//   with success, position, is_empty and entry_count on result. the
//   receiver cannot stall, so the result is taken in that cycle.
// a full insert, a search or remove on an empty list and an unknown func
// finish at once: done rises at the accepting edge and busy never rises.
//   an insert passes through ST_ALLOC, which writes the value and link, and a
//   search or remove walks from the head to the first equal entry or the last one.
// busy is low again from the edge that raises done, so the next request
//   can be taken after that edge.
//   the walk does one compare per cycle, set by the registered read of
//   the value and link rams that chase the next pointer.
// reset empties the list at once; no clearing pass is needed.
`default_nettype none

module ordered_list_engine
    import olist_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire request_t request,
    output logic          done,
    output result_t       result
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_WALK
    } state_t;

    state_t                state_reg, state_next;
    logic [FUNC_W-1:0]     func_reg, func_next;
    logic [DATA_WIDTH-1:0] value_reg, value_next;
    logic [IDX_W-1:0]      head_reg, head_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [IDX_W-1:0]      k_reg, k_next;
    logic [IDX_W-1:0]      cur_reg, cur_next;
    logic [IDX_W-1:0]      prev_reg, prev_next;
    logic                  done_reg, done_next;
    result_t               result_reg, result_next;

    logic                  finish;
    logic                  fin_success;
    logic [IDX_W-1:0]      fin_pos;

    logic                  val_we;
    logic                  link_we;
    logic [IDX_W-1:0]      link_waddr;
    logic [IDX_W-1:0]      link_wdata;
    logic [IDX_W-1:0]      rd_addr;
    logic [DATA_WIDTH-1:0] rd_value;
    logic [IDX_W-1:0]      rd_link;

    alloc_ctrl_t           alloc_ctrl;
    logic [IDX_W-1:0]      alloc_slot;

    olist_ram #(
        .WIDTH(DATA_WIDTH),
        .DEPTH(CAPACITY)
    ) u_values (
        .clk  (clk),
        .we   (val_we),
        .waddr(alloc_slot),
        .wdata(value_reg),
        .raddr(rd_addr),
        .rdata(rd_value)
    );

    olist_ram #(
        .WIDTH(IDX_W),
        .DEPTH(CAPACITY)
    ) u_links (
        .clk  (clk),
        .we   (link_we),
        .waddr(link_waddr),
        .wdata(link_wdata),
        .raddr(rd_addr),
        .rdata(rd_link)
    );

    olist_alloc #(
        .CAPACITY(CAPACITY)
    ) u_alloc (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (alloc_ctrl),
        .push_slot(cur_reg),
        .slot     (alloc_slot)
    );

    assign rd_addr = (state_reg == ST_WALK) ? rd_link : head_reg;

    always_comb
    begin
        state_next  = state_reg;
        func_next   = func_reg;
        value_next  = value_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        k_next      = k_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        finish      = 1'b0;
        fin_success = 1'b0;
        fin_pos     = '0;
        val_we      = 1'b0;
        link_we     = 1'b0;
        link_waddr  = alloc_slot;
        link_wdata  = head_reg;
        alloc_ctrl  = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    func_next  = request.func;
                    value_next = DATA_WIDTH'(request.value);
                    k_next     = '0;
                    cur_next   = head_reg;
                    prev_next  = head_reg;
                    case (request.func)
                        FUNC_INSERT:
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                finish = 1'b1;
                            end
                            else
                            begin
                                alloc_ctrl.pop = 1'b1;
                                state_next     = ST_ALLOC;
                            end
                        end
                        FUNC_SEARCH, FUNC_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                finish = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_WALK;
                            end
                        end
                        default:
                        begin
                            finish = 1'b1;
                        end
                    endcase
                end
            end
            ST_ALLOC:
            begin
                val_we      = 1'b1;
                link_we     = 1'b1;
                head_next   = alloc_slot;
                count_next  = count_reg + CNT_W'(1);
                fin_success = 1'b1;
                finish      = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_WALK:
            begin
                if (rd_value == value_reg)
                begin
                    fin_success = 1'b1;
                    finish      = 1'b1;
                    state_next  = ST_IDLE;
                    if (func_reg == FUNC_SEARCH)
                    begin
                        fin_pos = k_reg;
                    end
                    else
                    begin
                        if (k_reg == '0)
                        begin
                            head_next = rd_link;
                        end
                        else
                        begin
                            link_we    = 1'b1;
                            link_waddr = prev_reg;
                            link_wdata = rd_link;
                        end
                        alloc_ctrl.push = 1'b1;
                        count_next      = count_reg - CNT_W'(1);
                    end
                end
                else if (CNT_W'(k_reg) + CNT_W'(1) == count_reg)
                begin
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    k_next    = k_reg + IDX_W'(1);
                    prev_next = cur_reg;
                    cur_next  = rd_link;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (finish)
        begin
            done_next               = 1'b1;
            result_next.success     = fin_success;
            result_next.position    = POS_W'(fin_pos);
            result_next.is_empty    = (count_next == '0);
            result_next.entry_count = COUNT_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            func_reg   <= '0;
            value_reg  <= '0;
            head_reg   <= '0;
            count_reg  <= '0;
            k_reg      <= '0;
            cur_reg    <= '0;
            prev_reg   <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            func_reg   <= func_next;
            value_reg  <= value_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            k_reg      <= k_next;
            cur_reg    <= cur_next;
            prev_reg   <= prev_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !busy)
        else $error("ordered_list_engine: result strobe while still busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("ordered_list_engine: entry count past capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (CNT_W'(k_reg) < count_reg))
        else $error("ordered_list_engine: walk ran past the last entry");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ALLOC) |-> (count_reg < CNT_W'(CAPACITY)))
        else $error("ordered_list_engine: insert started on a full list");

endmodule

`default_nettype wire

// ----- verif/ordered_list_engine_tb.sv -----
// ordered_list_engine_tb: self-checking testbench for the ordered list engine
// predicts each result transaction from a queue model of the list, newest first
// depends on olist_pkg and rtl/ordered_list_engine.sv
`default_nettype none

module ordered_list_engine_tb
    import olist_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAPACITY      = 64;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 80;
    localparam int MAX_GAP       = 8;

    localparam logic [FUNC_W-1:0]         FUNC_UNUSED = 2'd3;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN   = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX   = 32'sh7fff_ffff;

    logic     clk;
    logic     rst_n   = 1'b0;
    logic     start   = 1'b0;
    request_t request = '0;
    logic     busy;
    logic     done;
    result_t  result;

    logic signed [VALUE_W-1:0] held_values[$];
    result_t                   expected_results[$];
    int                        errors       = 0;
    int                        stall_cycles = 0;
    int                        idle_pct     = 17;

    ordered_list_engine DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // list model: insert at the front, search and remove take the first match
    function automatic result_t apply_request(input request_t req);
        result_t res;
        int      hit;
        res = '0;
        hit = -1;
        if (req.func == FUNC_INSERT)
        begin
            if (held_values.size() < CAPACITY)
            begin
                held_values.push_front(req.value);
                res.success = 1'b1;
            end
        end
        else if (req.func == FUNC_SEARCH || req.func == FUNC_REMOVE)
        begin
            foreach (held_values[i])
                if (hit < 0 && held_values[i] == req.value)
                    hit = i;
            if (hit >= 0)
            begin
                res.success = 1'b1;
                if (req.func == FUNC_SEARCH)
                    res.position = POS_W'(hit);
                else
                    held_values.delete(hit);
            end
        end
        res.is_empty    = (held_values.size() == 0);
        res.entry_count = COUNT_W'(held_values.size());
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [7:0] expv,
                                        input logic [7:0] actv);
        if (expv !== actv)
        begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, expv, actv);
            errors++;
        end
    endfunction

    // result checking, prediction on acceptance and the stall watchdog
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none actual %p", $time, result);
                    errors++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("success", want.success, result.success);
                    check_field("position", want.position, result.position);
                    check_field("is_empty", want.is_empty, result.is_empty);
                    check_field("entry_count", want.entry_count, result.entry_count);
                end
            end
            if (start && !busy)
                expected_results.push_back(apply_request(request));
            if (done || (start && !busy))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
                $display("[ordered_list_engine] ERROR");
                $finish;
            end
        end
    end

    task automatic send_request(input logic [FUNC_W-1:0] op,
                                input logic signed [VALUE_W-1:0] operand);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(MAX_GAP, 1)) @(posedge clk);
        end
        start   <= 1'b1;
        request <= '{func: op, value: operand};
        do
            @(posedge clk);
        while (busy);
    endtask

    // operand mix: values already held, a small pool with the extremes, or fully random
    function automatic logic signed [VALUE_W-1:0] pick_value(input int held_pct);
        logic signed [VALUE_W-1:0] pool[8];
        pool = '{0, 1, -1, VALUE_MIN, VALUE_MAX, 7, 42, -100};
        if (held_values.size() != 0 && $urandom_range(99) < held_pct)
            return held_values[$urandom_range(held_values.size() - 1)];
        if ($urandom_range(99) < 55)
            return pool[$urandom_range(7)];
        return $urandom;
    endfunction

    task automatic test_empty_list;
        send_request(FUNC_SEARCH, 0);
        send_request(FUNC_REMOVE, VALUE_MIN);
        send_request(FUNC_UNUSED, VALUE_MAX);
    endtask

    task automatic test_basic_ops;
        send_request(FUNC_INSERT, VALUE_MAX);
        send_request(FUNC_INSERT, VALUE_MIN);
        send_request(FUNC_INSERT, 0);
        send_request(FUNC_INSERT, -1);
        send_request(FUNC_INSERT, 1);
        send_request(FUNC_SEARCH, VALUE_MAX);
        send_request(FUNC_SEARCH, 1);
        send_request(FUNC_SEARCH, VALUE_MIN);
        send_request(FUNC_SEARCH, 12345);
        send_request(FUNC_INSERT, -1);
        send_request(FUNC_SEARCH, -1);
        send_request(FUNC_REMOVE, -1);
        send_request(FUNC_SEARCH, -1);
        send_request(FUNC_REMOVE, 0);
        send_request(FUNC_REMOVE, VALUE_MAX);
        send_request(FUNC_REMOVE, 999);
        send_request(FUNC_UNUSED, -1);
        send_request(FUNC_SEARCH, VALUE_MIN);
        send_request(FUNC_REMOVE, 1);
        send_request(FUNC_REMOVE, -1);
        send_request(FUNC_REMOVE, VALUE_MIN);
        send_request(FUNC_SEARCH, 0);
    endtask

    task automatic test_full_store;
        logic signed [VALUE_W-1:0] filled[$];
        logic signed [VALUE_W-1:0] operand;
        int                        pick;
        for (int n = 0; n < CAPACITY; n++)
        begin
            operand = (n == 0) ? VALUE_MIN : (n == 1) ? VALUE_MAX : $urandom;
            filled.push_back(operand);
            send_request(FUNC_INSERT, operand);
        end
        send_request(FUNC_INSERT, 5);
        send_request(FUNC_SEARCH, VALUE_MIN);
        send_request(FUNC_SEARCH, filled[CAPACITY-1]);
        send_request(FUNC_SEARCH, 3);
        send_request(FUNC_REMOVE, VALUE_MIN);
        void'(filled.pop_front());
        send_request(FUNC_INSERT, 77);
        filled.push_back(77);
        send_request(FUNC_INSERT, 78);
        while (filled.size() != 0)
        begin
            pick = $urandom_range(filled.size() - 1);
            send_request(FUNC_REMOVE, filled[pick]);
            filled.delete(pick);
        end
        send_request(FUNC_REMOVE, 77);
    endtask

    // windows that lean towards filling or draining so the list swings from empty to full
    task automatic test_random(input int count, input int pct);
        logic [FUNC_W-1:0] op;
        int                roll;
        bit                filling;
        idle_pct = pct;
        filling  = 1'b1;
        for (int n = 0; n < count; n++)
        begin
            if (n % 60 == 0)
                filling = $urandom_range(1);
            roll = $urandom_range(99);
            if (roll < 4)
                op = FUNC_UNUSED;
            else if (roll < (filling ? 70 : 24))
                op = FUNC_INSERT;
            else if (roll < (filling ? 85 : 44))
                op = FUNC_SEARCH;
            else
                op = FUNC_REMOVE;
            send_request(op, pick_value(op == FUNC_INSERT ? 10 : 65));
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_basic_ops();
        test_full_store();
        test_random(150, 17);
        test_random(150, 50);
        test_random(150, 0);
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_results.size());
            errors++;
        end
        if (errors == 0)
            $display("[ordered_list_engine] OK");
        else
            $display("[ordered_list_engine] ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/olist_pkg.sv
rtl/olist_ram.sv
rtl/olist_alloc.sv
rtl/ordered_list_engine.sv
verif/ordered_list_engine_tb.sv
